FILE: sv/cwbs_pkg.sv
package cwbs_pkg;

	localparam int PIX_W = 19;
	localparam int BANK_W = 4;
	localparam int ADDR_W = 8;
	localparam int N_BANKS = 16;
	localparam int N_SLOTS = 4;
	localparam int SLOT_W = 2;
	localparam int IMAGE_SIDE_DEF = 28;

	// Write plan for one pixel, slots in issue order.
	typedef struct packed {
		logic [N_SLOTS-1:0]             take;
		logic [N_SLOTS-1:0][BANK_W-1:0] bank;
		logic                           wrap;
	} plan_t;

endpackage

FILE: sv/cwbs_plan.sv
module cwbs_plan #(
	parameter int IMAGE_SIDE = cwbs_pkg::IMAGE_SIDE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cwbs_pkg::PIX_W-1:0] pixel_value,
	input  logic                       plan_done,
	output logic                       plan_valid_s1,
	output cwbs_pkg::plan_t            plan_s1,
	output logic [cwbs_pkg::PIX_W-1:0] pixel_s1
);

	localparam int POS_W = $clog2(IMAGE_SIDE);
	localparam int TOP = IMAGE_SIDE - 1;
	localparam int LAST_EVEN = (TOP % 2 == 0) ? TOP : TOP - 1;
	localparam int LAST_ODD = (TOP % 2 == 1) ? TOP : TOP - 1;

	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic             accept;
	logic             row_a;
	logic             col_b;
	logic             even_even;
	logic [1:0]       row_half;
	logic [1:0]       col_half;
	logic             col_end;
	logic             row_end;
	cwbs_pkg::plan_t  plan_d;
	logic [cwbs_pkg::N_SLOTS-1:0] slot_r;
	logic [cwbs_pkg::N_SLOTS-1:0] slot_c;

	assign in_ready = !plan_valid_s1 || plan_done;
	assign accept = in_valid && in_ready;

	assign row_a = row_q[0];
	assign col_b = col_q[0];
	assign even_even = !row_a && !col_b;
	assign col_end = (col_q == POS_W'(TOP));
	assign row_end = (row_q == POS_W'(TOP));

	// half 0 drops the last index of its parity, half 1 the first
	assign row_half[0] = row_a ? (row_q != POS_W'(LAST_ODD)) : (row_q != POS_W'(LAST_EVEN));
	assign row_half[1] = (row_q[POS_W-1:1] != '0);
	assign col_half[0] = col_b ? (col_q != POS_W'(LAST_ODD)) : (col_q != POS_W'(LAST_EVEN));
	assign col_half[1] = (col_q[POS_W-1:1] != '0);

	// even/even goes column half first, other parities row half first
	assign slot_r = even_even ? 4'b1100 : 4'b1010;
	assign slot_c = even_even ? 4'b1010 : 4'b1100;

	always_comb begin
		for (int k = 0; k < cwbs_pkg::N_SLOTS; k++) begin
			plan_d.take[k] = row_half[slot_r[k]] && col_half[slot_c[k]];
			plan_d.bank[k] = {slot_r[k], row_a, slot_c[k], col_b};
		end
		plan_d.wrap = col_end && row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			plan_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				plan_valid_s1 <= 1'b1;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (plan_done) begin
				plan_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plan_s1 <= plan_d;
			pixel_s1 <= pixel_value;
		end
	end

endmodule

FILE: sv/cwbs_emit.sv
module cwbs_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        plan_valid_s1,
	input  cwbs_pkg::plan_t             plan_s1,
	input  logic [cwbs_pkg::PIX_W-1:0]  pixel_s1,
	output logic                        plan_done,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cwbs_pkg::BANK_W-1:0] bank_select,
	output logic [cwbs_pkg::ADDR_W-1:0] bank_address,
	output logic [cwbs_pkg::PIX_W-1:0]  pixel_out,
	output logic                        last_write
);

	logic [cwbs_pkg::ADDR_W-1:0]  count_q [cwbs_pkg::N_BANKS];
	logic [cwbs_pkg::N_SLOTS-1:0] issued_q;
	logic [cwbs_pkg::N_SLOTS-1:0] pending;
	logic [cwbs_pkg::N_SLOTS-1:0] pick;
	logic [cwbs_pkg::N_SLOTS-1:0] rest;
	logic [cwbs_pkg::SLOT_W-1:0]  sel;
	logic [cwbs_pkg::BANK_W-1:0]  sel_bank;
	logic                         found;
	logic                         load;
	logic                         final_beat;

	assign pending = plan_s1.take & ~issued_q;

	always_comb begin
		sel = '0;
		found = 1'b0;
		for (int k = 0; k < cwbs_pkg::N_SLOTS; k++) begin
			if (!found && pending[k]) begin
				sel = cwbs_pkg::SLOT_W'(k);
				found = 1'b1;
			end
		end
	end

	assign pick = cwbs_pkg::N_SLOTS'(1) << sel;
	assign rest = pending & ~pick;
	assign sel_bank = plan_s1.bank[sel];

	assign load = plan_valid_s1 && found && (!out_valid || out_ready);
	assign final_beat = load && (rest == '0);
	// a pixel with no writes leaves at once
	assign plan_done = plan_valid_s1 && (!found || final_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			issued_q <= '0;
			for (int b = 0; b < cwbs_pkg::N_BANKS; b++) begin
				count_q[b] <= '0;
			end
		end else begin
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (plan_done) begin
				issued_q <= '0;
			end else if (load) begin
				issued_q <= issued_q | pick;
			end
			// end of image: every bank address restarts
			if (plan_done && plan_s1.wrap) begin
				for (int b = 0; b < cwbs_pkg::N_BANKS; b++) begin
					count_q[b] <= '0;
				end
			end else if (load) begin
				count_q[sel_bank] <= count_q[sel_bank] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_select <= sel_bank;
			bank_address <= count_q[sel_bank];
			pixel_out <= pixel_s1;
			last_write <= (rest == '0);
		end
	end

endmodule

FILE: sv/conv_window_bank_scatter_unit.sv
// A pixel's plan is registered in the plan stage, then each of its write beats in
// the write output register. Beats go out one per cycle while out_ready is high,
// 1 to 4 per pixel (4 for an interior pixel), set by the single write output register.
// A new pixel is taken while the previous pixel's last write waits.
// Reset (arst_n low, asynchronous): position, bank addresses and valids clear.
module conv_window_bank_scatter_unit #(
	parameter int IMAGE_SIDE = cwbs_pkg::IMAGE_SIDE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cwbs_pkg::PIX_W-1:0]  pixel_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cwbs_pkg::BANK_W-1:0] bank_select,
	output logic [cwbs_pkg::ADDR_W-1:0] bank_address,
	output logic [cwbs_pkg::PIX_W-1:0]  pixel_out,
	output logic                        last_write
);

	logic                       plan_valid_s1;
	logic                       plan_done;
	cwbs_pkg::plan_t            plan_s1;
	logic [cwbs_pkg::PIX_W-1:0] pixel_s1;

	cwbs_plan #(
		.IMAGE_SIDE(IMAGE_SIDE)
	) u_plan (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_value   (pixel_value),
		.plan_done     (plan_done),
		.plan_valid_s1 (plan_valid_s1),
		.plan_s1       (plan_s1),
		.pixel_s1      (pixel_s1)
	);

	cwbs_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.plan_valid_s1 (plan_valid_s1),
		.plan_s1       (plan_s1),
		.pixel_s1      (pixel_s1),
		.plan_done     (plan_done),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bank_select   (bank_select),
		.bank_address  (bank_address),
		.pixel_out     (pixel_out),
		.last_write    (last_write)
	);

endmodule

FILE: sv/cwbs_checker.sv
module cwbs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [cwbs_pkg::BANK_W-1:0] bank_select,
	input logic [cwbs_pkg::ADDR_W-1:0] bank_address,
	input logic [cwbs_pkg::PIX_W-1:0]  pixel_out,
	input logic                        last_write
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("write beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(bank_select) && $stable(bank_address)
			&& $stable(pixel_out) && $stable(last_write))
		else $error("write beat changed while stalled");

	// a pixel only blocks input while its writes are still coming out
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input stalled with no write pending");

	// writes of one pixel go out back to back
	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_write |=> out_valid)
		else $error("gap inside a pixel's writes");

endmodule

bind conv_window_bank_scatter_unit cwbs_checker u_cwbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.bank_select  (bank_select),
	.bank_address (bank_address),
	.pixel_out    (pixel_out),
	.last_write   (last_write)
);
